### rtl/cfq_pkg.sv
// Shared types, constants and helper functions for the circular FIFO queue.
package cfq_pkg;

  localparam int RING_DEPTH = 512;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CAP_W      = 9;
  localparam int MAX_CAP    = RING_DEPTH - 1;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(500);

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CAP_W-1:0]      cap_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_CLR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic cfg_wr;
  } ctl_t;

  function automatic ptr_t sat_cap(input cap_t value);
    if (int'(value) > MAX_CAP) begin
      return ptr_t'(MAX_CAP);
    end
    return ptr_t'(value);
  endfunction

  function automatic ptr_t adv(input ptr_t idx, input ptr_t cap);
    if (idx >= cap) begin
      return '0;
    end
    return idx + ptr_t'(1);
  endfunction

  function automatic ptr_t used(input ptr_t head, input ptr_t tail, input ptr_t cap);
    if (tail >= head) begin
      return tail - head;
    end
    return cap - head + tail + ptr_t'(1);
  endfunction

endpackage

### rtl/cfq_ifs.sv
// Request, response and configuration channel interfaces.
interface cfq_req_if;
  logic                 valid;
  logic                 ready;
  cfq_pkg::cmd_t        command;
  cfq_pkg::data_t       item_in;

  modport source (output valid, output command, output item_in, input ready);
  modport sink   (input valid, input command, input item_in, output ready);
endinterface

interface cfq_rsp_if;
  logic                 valid;
  logic                 ready;
  cfq_pkg::data_t       item_out;
  cfq_pkg::status_t     status;
  cfq_pkg::cap_t        count;
  logic                 is_empty;
  logic                 is_full;

  modport source (output valid, output item_out, output status, output count,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input item_out, input status, input count,
                  input is_empty, input is_full, output ready);
endinterface

interface cfq_cfg_if;
  logic                 valid;
  logic                 ready;
  cfq_pkg::cap_t        data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/circular_fifo_queue.sv
// Top level of the circular FIFO queue: controller plus datapath.
//
// channel  dir  handshake      payload
// req      in   valid/ready    command[1:0], item_in[31:0]
// rsp      out  valid/ready    item_out[31:0], status[1:0], count[8:0], is_empty, is_full
// cfg      in   valid/ready    data[8:0] (capacity)
//
// Each transaction runs through capture with storage read, execute and result hold.
// The registered storage read sets the capture cycle; the next request waits for the result.
// A stalled result holds until rsp.ready; req and cfg are not taken meanwhile.
// Reset (synchronous, rst) empties the queue and loads capacity 500; storage is not cleared.
// A cfg transaction empties the queue; it is taken only when no request is offered.
module circular_fifo_queue (
  input logic        clk,
  input logic        rst,
  cfq_req_if.sink    req,
  cfq_rsp_if.source  rsp,
  cfq_cfg_if.sink    cfg
);

  cfq_pkg::ctl_t ctl;

  cfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .ctl       (ctl)
  );

  cfq_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .command  (req.command),
    .item_in  (req.item_in),
    .cfg_data (cfg.data),
    .item_out (rsp.item_out),
    .status   (rsp.status),
    .count    (rsp.count),
    .is_empty (rsp.is_empty),
    .is_full  (rsp.is_full)
  );

endmodule

### rtl/cfq_ctrl.sv
// Controller state machine sequencing capture, execute and result hold.
module cfq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  output cfq_pkg::ctl_t ctl
);

  cfq_pkg::state_t state;
  cfq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    cfg_ready   = 1'b0;
    rsp_valid   = 1'b0;
    ctl         = '0;
    unique case (state)
      cfq_pkg::S_IDLE: begin
        req_ready   = 1'b1;
        cfg_ready   = !req_valid;
        ctl.capture = req_valid;
        ctl.cfg_wr  = cfg_valid && !req_valid;
        if (req_valid) begin
          state_next = cfq_pkg::S_EXEC;
        end
      end
      cfq_pkg::S_EXEC: begin
        ctl.execute = 1'b1;
        state_next  = cfq_pkg::S_HOLD;
      end
      cfq_pkg::S_HOLD: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = cfq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cfq_pkg::S_IDLE;
      end
    endcase
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(rsp_valid && req_ready))
    else $error("request accepted while a result is held");

  a_exec_once: assert property (@(posedge clk) disable iff (rst)
    ctl.execute |=> !ctl.execute && rsp_valid)
    else $error("execute not followed by result hold");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.cfg_wr |-> !ctl.capture && !ctl.execute && !rsp_valid)
    else $error("configuration write while busy");

endmodule

### rtl/cfq_dp.sv
// Datapath: ring storage, head and tail pointers, capacity and result registers.
module cfq_dp (
  input  logic             clk,
  input  logic             rst,
  input  cfq_pkg::ctl_t    ctl,
  input  cfq_pkg::cmd_t    command,
  input  cfq_pkg::data_t   item_in,
  input  cfq_pkg::cap_t    cfg_data,
  output cfq_pkg::data_t   item_out,
  output cfq_pkg::status_t status,
  output cfq_pkg::cap_t    count,
  output logic             is_empty,
  output logic             is_full
);

  cfq_pkg::data_t   mem [cfq_pkg::RING_DEPTH];
  cfq_pkg::ptr_t    cap;
  cfq_pkg::ptr_t    head;
  cfq_pkg::ptr_t    tail;
  cfq_pkg::cmd_t    cmd_q;
  cfq_pkg::data_t   data_q;
  cfq_pkg::data_t   rd_data;

  cfq_pkg::ptr_t    head_next;
  cfq_pkg::ptr_t    tail_next;
  cfq_pkg::data_t   read_val;
  cfq_pkg::status_t status_next;
  cfq_pkg::ptr_t    tail_adv;
  logic             wr_en;
  logic             cur_empty;
  logic             cur_full;

  assign tail_adv  = cfq_pkg::adv(tail, cap);
  assign cur_empty = (head == tail);
  assign cur_full  = (tail_adv == head);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      rd_data <= mem[cfq_pkg::adv(head, cap)];
      cmd_q   <= command;
      data_q  <= item_in;
    end
    if (wr_en) begin
      mem[tail_adv] <= data_q;
    end
  end

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    read_val    = '0;
    status_next = cfq_pkg::ST_OK;
    wr_en       = 1'b0;
    unique case (cmd_q)
      cfq_pkg::CMD_ENQ: begin
        if (cur_full) begin
          status_next = cfq_pkg::ST_OVERFLOW;
        end else begin
          tail_next = tail_adv;
          wr_en     = ctl.execute;
        end
      end
      cfq_pkg::CMD_DEQ: begin
        if (cur_empty) begin
          status_next = cfq_pkg::ST_UNDERFLOW;
        end else begin
          head_next = cfq_pkg::adv(head, cap);
          read_val  = rd_data;
        end
      end
      cfq_pkg::CMD_PEEK: begin
        if (cur_empty) begin
          status_next = cfq_pkg::ST_UNDERFLOW;
        end else begin
          read_val = rd_data;
        end
      end
      cfq_pkg::CMD_CLR: begin
        head_next = '0;
        tail_next = '0;
      end
      default: begin
        head_next = head;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap      <= cfq_pkg::sat_cap(cfq_pkg::CAP_RESET);
      head     <= '0;
      tail     <= '0;
      item_out <= '0;
      status   <= cfq_pkg::ST_OK;
      count    <= '0;
      is_empty <= 1'b1;
      is_full  <= 1'b0;
    end else if (ctl.cfg_wr) begin
      cap  <= cfq_pkg::sat_cap(cfg_data);
      head <= '0;
      tail <= '0;
    end else if (ctl.execute) begin
      head     <= head_next;
      tail     <= tail_next;
      item_out <= read_val;
      status   <= status_next;
      count    <= cfq_pkg::CAP_W'(cfq_pkg::used(head_next, tail_next, cap));
      is_empty <= (head_next == tail_next);
      is_full  <= (cfq_pkg::adv(tail_next, cap) == head_next);
    end
  end

  a_head_in_ring: assert property (@(posedge clk) disable iff (rst)
    head <= cap && tail <= cap)
    else $error("pointer outside ring");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    status == cfq_pkg::ST_OVERFLOW |-> is_full)
    else $error("overflow reported on a queue that is not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    status == cfq_pkg::ST_UNDERFLOW |-> is_empty && item_out == '0)
    else $error("underflow reported on a non-empty queue");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.execute && cmd_q == cfq_pkg::CMD_ENQ && !cur_full |=> !is_empty)
    else $error("queue empty after a successful enqueue");

endmodule

### dv/circular_fifo_queue_test.sv
// Self-checking testbench for circular_fifo_queue: directed table, then randomized command traffic.
module circular_fifo_queue_test;

  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES        = 9;

  typedef struct {
    cfq_pkg::data_t   item;
    cfq_pkg::status_t st;
    cfq_pkg::cap_t    cnt;
    logic             emp;
    logic             ful;
  } fifo_result_t;

  typedef struct {
    bit               cfg_row;
    int               cap_val;
    cfq_pkg::cmd_t    cmd;
    cfq_pkg::data_t   data;
    bit               typed;
    cfq_pkg::data_t   item;
    cfq_pkg::status_t st;
    int               cnt;
    bit               emp;
    bit               ful;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;

  cfq_req_if req_ch();
  cfq_rsp_if rsp_ch();
  cfq_cfg_if cfg_ch();

  circular_fifo_queue DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #5 clk = ~clk;

  cfq_pkg::data_t slots [cfq_pkg::RING_DEPTH];
  int             queue_cap = 500;
  int             head_slot = 0;
  int             tail_slot = 0;
  fifo_result_t   pending_results [$];
  int             mismatch_count = 0;
  bit             calm = 1'b0;

  step_row_t dir_plan [0:24] = '{
    '{0, 0,   cfq_pkg::CMD_DEQ,  32'h0,        1, 32'h0,        cfq_pkg::ST_UNDERFLOW, 0, 1, 0},
    '{0, 0,   cfq_pkg::CMD_PEEK, 32'h0,        1, 32'h0,        cfq_pkg::ST_UNDERFLOW, 0, 1, 0},
    '{0, 0,   cfq_pkg::CMD_ENQ,  32'hFFFFFFFF, 1, 32'h0,        cfq_pkg::ST_OK,        1, 0, 0},
    '{0, 0,   cfq_pkg::CMD_ENQ,  32'h00000000, 1, 32'h0,        cfq_pkg::ST_OK,        2, 0, 0},
    '{0, 0,   cfq_pkg::CMD_PEEK, 32'h0,        1, 32'hFFFFFFFF, cfq_pkg::ST_OK,        2, 0, 0},
    '{0, 0,   cfq_pkg::CMD_DEQ,  32'h0,        1, 32'hFFFFFFFF, cfq_pkg::ST_OK,        1, 0, 0},
    '{0, 0,   cfq_pkg::CMD_DEQ,  32'h0,        1, 32'h00000000, cfq_pkg::ST_OK,        0, 1, 0},
    '{0, 0,   cfq_pkg::CMD_ENQ,  32'hA5A5A5A5, 1, 32'h0,        cfq_pkg::ST_OK,        1, 0, 0},
    '{0, 0,   cfq_pkg::CMD_CLR,  32'hFFFFFFFF, 1, 32'h0,        cfq_pkg::ST_OK,        0, 1, 0},
    '{0, 0,   cfq_pkg::CMD_PEEK, 32'h0,        1, 32'h0,        cfq_pkg::ST_UNDERFLOW, 0, 1, 0},
    '{1, 1,   cfq_pkg::CMD_ENQ,  32'h0,        0, 32'h0,        cfq_pkg::ST_OK,        0, 0, 0},
    '{0, 0,   cfq_pkg::CMD_ENQ,  32'h5A5A5A5A, 1, 32'h0,        cfq_pkg::ST_OK,        1, 0, 1},
    '{0, 0,   cfq_pkg::CMD_ENQ,  32'h12345678, 1, 32'h0,        cfq_pkg::ST_OVERFLOW,  1, 0, 1},
    '{0, 0,   cfq_pkg::CMD_PEEK, 32'h0,        1, 32'h5A5A5A5A, cfq_pkg::ST_OK,        1, 0, 1},
    '{0, 0,   cfq_pkg::CMD_DEQ,  32'h0,        1, 32'h5A5A5A5A, cfq_pkg::ST_OK,        0, 1, 0},
    '{1, 0,   cfq_pkg::CMD_ENQ,  32'h0,        0, 32'h0,        cfq_pkg::ST_OK,        0, 0, 0},
    '{0, 0,   cfq_pkg::CMD_ENQ,  32'h00000001, 1, 32'h0,        cfq_pkg::ST_OVERFLOW,  0, 1, 1},
    '{0, 0,   cfq_pkg::CMD_DEQ,  32'h0,        1, 32'h0,        cfq_pkg::ST_UNDERFLOW, 0, 1, 1},
    '{0, 0,   cfq_pkg::CMD_PEEK, 32'h0,        1, 32'h0,        cfq_pkg::ST_UNDERFLOW, 0, 1, 1},
    '{0, 0,   cfq_pkg::CMD_CLR,  32'h0,        1, 32'h0,        cfq_pkg::ST_OK,        0, 1, 1},
    '{1, 511, cfq_pkg::CMD_ENQ,  32'h0,        0, 32'h0,        cfq_pkg::ST_OK,        0, 0, 0},
    '{0, 0,   cfq_pkg::CMD_ENQ,  32'h80000000, 1, 32'h0,        cfq_pkg::ST_OK,        1, 0, 0},
    '{0, 0,   cfq_pkg::CMD_ENQ,  32'h7FFFFFFF, 0, 32'h0,        cfq_pkg::ST_OK,        0, 0, 0},
    '{0, 0,   cfq_pkg::CMD_DEQ,  32'h0,        0, 32'h0,        cfq_pkg::ST_OK,        0, 0, 0},
    '{0, 0,   cfq_pkg::CMD_CLR,  32'h0,        0, 32'h0,        cfq_pkg::ST_OK,        0, 0, 0}
  };

  int phase_caps [PHASES] = '{3, 1, 16, 0, 2, 511, 0, 0, 500};

  function automatic int ring_next(input int idx);
    return (idx + 1 >= queue_cap + 1) ? 0 : idx + 1;
  endfunction

  function automatic fifo_result_t next_fifo_result(input cfq_pkg::cmd_t c,
                                                    input cfq_pkg::data_t d);
    fifo_result_t r;
    bit was_empty;
    bit was_full;
    int n;
    was_empty = (head_slot == tail_slot);
    was_full  = (ring_next(tail_slot) == head_slot);
    r.item = '0;
    r.st   = cfq_pkg::ST_OK;
    case (c)
      cfq_pkg::CMD_ENQ: begin
        if (was_full) begin
          r.st = cfq_pkg::ST_OVERFLOW;
        end else begin
          tail_slot = ring_next(tail_slot);
          slots[tail_slot] = d;
        end
      end
      cfq_pkg::CMD_DEQ: begin
        if (was_empty) begin
          r.st = cfq_pkg::ST_UNDERFLOW;
        end else begin
          head_slot = ring_next(head_slot);
          r.item = slots[head_slot];
        end
      end
      cfq_pkg::CMD_PEEK: begin
        if (was_empty) begin
          r.st = cfq_pkg::ST_UNDERFLOW;
        end else begin
          r.item = slots[ring_next(head_slot)];
        end
      end
      default: begin
        head_slot = 0;
        tail_slot = 0;
      end
    endcase
    n = (tail_slot >= head_slot) ? tail_slot - head_slot
                                 : queue_cap + 1 - head_slot + tail_slot;
    r.cnt = cfq_pkg::cap_t'(n);
    r.emp = (head_slot == tail_slot);
    r.ful = (ring_next(tail_slot) == head_slot);
    return r;
  endfunction

  task automatic issue(input cfq_pkg::cmd_t c, input cfq_pkg::data_t d, input bit typed,
                       input fifo_result_t typed_res);
    fifo_result_t r;
    if (!calm) begin
      while ($urandom_range(0, 99) < 36) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= c;
    req_ch.item_in <= d;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    r = next_fifo_result(c, d);
    if (typed) begin
      r = typed_res;
    end
    pending_results.push_back(r);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input int cap);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cfq_pkg::cap_t'(cap);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    queue_cap = cap;
    head_slot = 0;
    tail_slot = 0;
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 36);
    end
  end

  always @(posedge clk) begin
    fifo_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected transaction: item=%h status=%0d count=%0d empty=%b full=%b",
                   rsp_ch.item_out, rsp_ch.status, rsp_ch.count, rsp_ch.is_empty,
                   rsp_ch.is_full);
        end
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.item_out !== want.item || rsp_ch.status !== want.st ||
            rsp_ch.count !== want.cnt || rsp_ch.is_empty !== want.emp ||
            rsp_ch.is_full !== want.ful) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: exp item=%h status=%0d count=%0d empty=%b full=%b",
                     want.item, want.st, want.cnt, want.emp, want.ful);
            $display("          got item=%h status=%0d count=%0d empty=%b full=%b",
                     rsp_ch.item_out, rsp_ch.status, rsp_ch.count, rsp_ch.is_empty,
                     rsp_ch.is_full);
          end
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    fifo_result_t typed_res;
    step_row_t row;
    int cap;
    int enq_pct;
    int pick;
    cfq_pkg::cmd_t c;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.command = cfq_pkg::CMD_ENQ;
    req_ch.item_in = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_plan[i]) begin
      row = dir_plan[i];
      if (row.cfg_row) begin
        write_capacity(row.cap_val);
      end else begin
        typed_res.item = row.item;
        typed_res.st   = row.st;
        typed_res.cnt  = cfq_pkg::cap_t'(row.cnt);
        typed_res.emp  = row.emp;
        typed_res.ful  = row.ful;
        issue(row.cmd, row.data, row.typed, typed_res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 6) begin
        cap = $urandom_range(1, 40);
      end else if (p == 7) begin
        cap = $urandom_range(4, 12);
      end else begin
        cap = phase_caps[p];
      end
      write_capacity(cap);
      calm = (p == 2);
      for (int k = 0; k < 82; k++) begin
        if (k == 41) begin
          wait_drained();
        end
        enq_pct = (k < 41) ? 65 : 30;
        pick = $urandom_range(0, 99);
        if (pick < enq_pct) begin
          c = cfq_pkg::CMD_ENQ;
        end else if (pick >= 96) begin
          c = cfq_pkg::CMD_CLR;
        end else if ($urandom_range(0, 3) == 0) begin
          c = cfq_pkg::CMD_PEEK;
        end else begin
          c = cfq_pkg::CMD_DEQ;
        end
        issue(c, cfq_pkg::data_t'($urandom()), 1'b0, typed_res);
      end
      calm = 1'b0;
    end

    wait_drained();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
